[hdl/lopt_pkg.sv]
// lopt_pkg: shared codes and types of the open partition table.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package lopt_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EVICT_ENABLE = 1'b1;
	localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET  = 5'd16;

	// Request kinds; the high bit alone selects clear all
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_ACCESS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

	localparam int OUTCOME_W = 3;
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT       = 3'd0,
		OUT_OPENED    = 3'd1,
		OUT_EVICTED   = 3'd2,
		OUT_REFUSED   = 3'd3,
		OUT_RELEASED  = 3'd4,
		OUT_NOT_FOUND = 3'd5,
		OUT_CLEARED   = 3'd6
	} outcome_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	// What the rank rewrite sweep does to each slot
	typedef enum logic [1:0] {
		UPD_HIT = 2'd0,
		UPD_REL = 2'd1,
		UPD_INS = 2'd2
	} upd_mode_t;

endpackage

[hdl/lopt_if.sv]
// lopt_if: valid/ready channels of the open partition table (request and response).
// Depends on lopt_pkg for field widths.
interface lopt_req_if #(
	parameter int ID_BITS = 32
) ();
	logic                            valid;
	logic                            ready;
	logic [lopt_pkg::KIND_W-1:0]     kind;
	logic [ID_BITS-1:0]              partition_id;

	modport source (output valid, kind, partition_id, input ready);
	modport sink   (input valid, kind, partition_id, output ready);
endinterface

interface lopt_rsp_if #(
	parameter int ID_BITS = 32,
	parameter int CNT_W   = 5
) ();
	logic                            valid;
	logic                            ready;
	logic [lopt_pkg::OUTCOME_W-1:0]  outcome;
	logic [ID_BITS-1:0]              evicted_id;
	logic [CNT_W-1:0]                open_count;

	modport source (output valid, outcome, evicted_id, open_count, input ready);
	modport sink   (input valid, outcome, evicted_id, open_count, output ready);
endinterface

[hdl/lopt_ram.sv]
// lopt_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module lopt_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data_q <= mem_q[raddr];
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/lru_open_partition_table_unit.sv]
// lru_open_partition_table_unit: fully associative LRU table of open partition ids.
// Depends on lopt_pkg, lopt_if (lopt_req_if, lopt_rsp_if) and lopt_ram.
//
//  channel  dir  words                                  handshake
//  -------  ---  -------------------------------------  ---------------------
//  req      in   kind, partition_id                     valid/ready
//  rsp      out  outcome, evicted_id, open_count        valid/ready
//  cfg      in   cfg_index, cfg_data                    cfg_we, no back-pressure
//
// Sequence: scan, decide, rank rewrite (hit, release, insert), load. A refused access and
// a release that finds nothing skip the rewrite; a clear skips the scan and the rewrite.
// The unit returns to idle before it takes the next word. The single RAM read port and
// the one id/rank compare unit make each sweep visit the slots one at a time.
// Reset: arst_n empties the table at once (valid bits are flops); no clearing pass.
// Stalls: req is taken only in idle; a held response stalls the next item in its last cycle.
module lru_open_partition_table_unit #(
	parameter int ENTRIES = 16,
	parameter int ID_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	lopt_req_if.sink                          req,
	lopt_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [lopt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lopt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int RANK_W = IDX_W;
	localparam int WORD_W = RANK_W + ID_BITS;
	localparam int CMP_W  = (CNT_W > lopt_pkg::CFG_DATA_W) ? CNT_W : lopt_pkg::CFG_DATA_W;

	// Control state
	lopt_pkg::state_t                  state_q;
	logic [lopt_pkg::CFG_DATA_W-1:0]   cap_q;
	logic                              evict_en_q;
	logic [ENTRIES-1:0]                valid_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  cnt_q;      // sweep address counter, 0..ENTRIES
	logic                              pend_s1;    // RAM read in flight
	logic                              hit_q;
	logic                              lru_q;
	logic                              free_q;
	logic                              out_valid_q;

	// Payload
	logic [lopt_pkg::KIND_W-1:0]       kind_q;
	logic [ID_BITS-1:0]                key_q;
	logic [IDX_W-1:0]                  idx_s1;
	logic [IDX_W-1:0]                  hit_idx_q;
	logic [RANK_W-1:0]                 hit_rank_q;
	logic [IDX_W-1:0]                  lru_idx_q;
	logic [ID_BITS-1:0]                lru_id_q;
	logic [IDX_W-1:0]                  free_idx_q;
	lopt_pkg::upd_mode_t               mode_q;
	logic [IDX_W-1:0]                  ins_idx_q;
	lopt_pkg::outcome_t                res_outcome_q;
	logic [ID_BITS-1:0]                res_evicted_q;
	logic [lopt_pkg::OUTCOME_W-1:0]    out_outcome_q;
	logic [ID_BITS-1:0]                out_evicted_q;
	logic [CNT_W-1:0]                  out_count_q;

	// RAM port
	logic                              ram_we;
	logic [WORD_W-1:0]                 ram_wdata;
	logic [WORD_W-1:0]                 ram_rdata;
	logic [RANK_W-1:0]                 rd_rank;
	logic [ID_BITS-1:0]                rd_id;

	// Sweep and compare unit
	logic                              req_fire;
	logic                              rsp_free;
	logic                              sweeping;
	logic                              issue;
	logic                              sweep_end;
	logic                              v_s1;
	logic                              scan_id_eq;
	logic                              scan_lru_eq;
	logic                              scan_free;
	logic                              scan_step;
	logic [RANK_W-1:0]                 rank_delta;
	logic                              rank_zero;
	logic [RANK_W-1:0]                 upd_rank;
	logic [ID_BITS-1:0]                upd_id;

	// Decision
	logic [CMP_W-1:0]                  cap_ext;
	logic [CMP_W-1:0]                  eff_cap;
	logic                              full;
	logic                              is_clear;
	logic                              is_release;
	logic                              evict_now;
	logic                              use_lru;
	logic [IDX_W-1:0]                  f_idx;
	logic                              can_ins;
	lopt_pkg::outcome_t                dec_outcome;
	logic [ID_BITS-1:0]                dec_evicted;
	logic                              dec_update;
	lopt_pkg::upd_mode_t               dec_mode;
	logic                              dec_clear;
	logic                              dec_drop;
	logic [IDX_W-1:0]                  dec_drop_idx;
	logic                              dec_set;
	logic [CNT_W-1:0]                  dec_count;

	// ------------------------------------------------------------------
	// Slot store: {rank, id} per slot. Ids are only read while the slot's
	// valid bit is set, so the store needs no clearing.
	// ------------------------------------------------------------------
	lopt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_slot_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (idx_s1),
		.wdata   (ram_wdata),
		.raddr   (cnt_q[IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	assign rd_rank = ram_rdata[WORD_W-1 -: RANK_W];
	assign rd_id   = ram_rdata[ID_BITS-1:0];

	assign req_fire  = req.valid && req.ready;
	assign rsp_free  = !out_valid_q || rsp.ready;
	assign sweeping  = (state_q == lopt_pkg::ST_SCAN) || (state_q == lopt_pkg::ST_UPDATE);
	assign sweep_end = (cnt_q == CNT_W'(ENTRIES));
	// Issue one read per cycle until the counter passes the last slot
	assign issue     = sweeping && !sweep_end;

	// Compare unit: one id compare and one rank compare on the word just read
	assign v_s1        = valid_q[idx_s1];
	assign scan_id_eq  = v_s1 && (rd_id == key_q);
	assign scan_lru_eq = v_s1 && (CNT_W'(rd_rank) == (count_q - CNT_W'(1)));
	assign scan_free   = !v_s1;
	assign scan_step   = (state_q == lopt_pkg::ST_SCAN) && pend_s1;

	// Rank rewrite: one shared adder steps a rank up, down or not at all,
	// and the target slot of a hit or insert is forced to most recent.
	always_comb begin
		rank_delta = '0;
		rank_zero  = 1'b0;
		upd_id     = rd_id;
		case (mode_q)
			lopt_pkg::UPD_HIT: begin
				if (idx_s1 == hit_idx_q) begin
					rank_zero = 1'b1;
				end else if (v_s1 && (rd_rank < hit_rank_q)) begin
					rank_delta = RANK_W'(1);
				end
			end
			lopt_pkg::UPD_REL: begin
				if (v_s1 && (rd_rank > hit_rank_q)) begin
					rank_delta = '1;
				end
			end
			lopt_pkg::UPD_INS: begin
				if (idx_s1 == ins_idx_q) begin
					rank_zero = 1'b1;
					upd_id    = key_q;
				end else if (v_s1) begin
					rank_delta = RANK_W'(1);
				end
			end
			default: begin
				rank_delta = '0;
			end
		endcase
		upd_rank = rank_zero ? '0 : (rd_rank + rank_delta);
	end

	assign ram_we    = (state_q == lopt_pkg::ST_UPDATE) && pend_s1;
	assign ram_wdata = {upd_rank, upd_id};

	// ------------------------------------------------------------------
	// Decision after the scan. A capacity of zero acts as one, and one
	// above the table size acts as the table size.
	// ------------------------------------------------------------------
	assign cap_ext    = CMP_W'(cap_q);
	assign eff_cap    = (cap_ext == '0) ? CMP_W'(1) :
	                    ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
	assign full       = CMP_W'(count_q) >= eff_cap;
	assign is_clear   = (kind_q & lopt_pkg::KIND_CLEAR) != '0;
	assign is_release = (kind_q == lopt_pkg::KIND_RELEASE);
	assign evict_now  = full && lru_q;
	// The evicted slot counts as free when it is the lowest-numbered one
	assign use_lru    = evict_now && (!free_q || (lru_idx_q < free_idx_q));
	assign f_idx      = use_lru ? lru_idx_q : free_idx_q;
	assign can_ins    = evict_now || free_q;

	always_comb begin
		dec_outcome  = lopt_pkg::OUT_HIT;
		dec_evicted  = '0;
		dec_update   = 1'b0;
		dec_mode     = lopt_pkg::UPD_HIT;
		dec_clear    = 1'b0;
		dec_drop     = 1'b0;
		dec_drop_idx = hit_idx_q;
		dec_set      = 1'b0;
		dec_count    = count_q;
		if (is_clear) begin
			dec_outcome = lopt_pkg::OUT_CLEARED;
			dec_clear   = 1'b1;
			dec_count   = '0;
		end else if (is_release) begin
			if (hit_q) begin
				dec_outcome = lopt_pkg::OUT_RELEASED;
				dec_update  = 1'b1;
				dec_mode    = lopt_pkg::UPD_REL;
				dec_drop    = 1'b1;
				dec_count   = count_q - CNT_W'(1);
			end else begin
				dec_outcome = lopt_pkg::OUT_NOT_FOUND;
			end
		end else if (hit_q) begin
			// A hit stays a hit even when the table is full
			dec_outcome = lopt_pkg::OUT_HIT;
			dec_update  = 1'b1;
			dec_mode    = lopt_pkg::UPD_HIT;
		end else if ((full && !evict_en_q) || !can_ins) begin
			dec_outcome = lopt_pkg::OUT_REFUSED;
		end else begin
			dec_outcome  = evict_now ? lopt_pkg::OUT_EVICTED : lopt_pkg::OUT_OPENED;
			dec_evicted  = evict_now ? lru_id_q : '0;
			dec_update   = 1'b1;
			dec_mode     = lopt_pkg::UPD_INS;
			dec_drop     = evict_now;
			dec_drop_idx = lru_idx_q;
			dec_set      = 1'b1;
			dec_count    = evict_now ? count_q : (count_q + CNT_W'(1));
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lopt_pkg::ST_IDLE;
			cap_q       <= lopt_pkg::CAPACITY_RESET;
			evict_en_q  <= 1'b1;
			valid_q     <= '0;
			count_q     <= '0;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			lru_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lopt_pkg::REG_CAPACITY:     cap_q      <= cfg_data;
					lopt_pkg::REG_EVICT_ENABLE: evict_en_q <= cfg_data[0];
					default:                    cap_q      <= cap_q;
				endcase
			end

			pend_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			// Latch the first match, the least recent slot and the first free slot
			if (scan_step) begin
				if (scan_id_eq) begin
					hit_q <= 1'b1;
				end
				if (scan_lru_eq) begin
					lru_q <= 1'b1;
				end
				if (scan_free) begin
					free_q <= 1'b1;
				end
			end

			// Drop the response once taken; a new one may replace it below
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				lopt_pkg::ST_IDLE: begin
					if (req_fire) begin
						hit_q  <= 1'b0;
						lru_q  <= 1'b0;
						free_q <= 1'b0;
						cnt_q  <= '0;
						state_q <= ((req.kind & lopt_pkg::KIND_CLEAR) != '0) ?
						           lopt_pkg::ST_DECIDE : lopt_pkg::ST_SCAN;
					end
				end
				lopt_pkg::ST_SCAN: begin
					if (sweep_end) begin
						state_q <= lopt_pkg::ST_DECIDE;
					end
				end
				lopt_pkg::ST_DECIDE: begin
					if (dec_clear) begin
						valid_q <= '0;
					end else begin
						if (dec_drop) begin
							valid_q[dec_drop_idx] <= 1'b0;
						end
						if (dec_set) begin
							valid_q[f_idx] <= 1'b1;
						end
					end
					count_q <= dec_count;
					cnt_q   <= '0;
					state_q <= dec_update ? lopt_pkg::ST_UPDATE : lopt_pkg::ST_FINISH;
				end
				lopt_pkg::ST_UPDATE: begin
					if (sweep_end) begin
						state_q <= lopt_pkg::ST_FINISH;
					end
				end
				lopt_pkg::ST_FINISH: begin
					// Hold until the response register is free
					if (rsp_free) begin
						out_valid_q <= 1'b1;
						state_q     <= lopt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lopt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req.kind;
			key_q  <= req.partition_id;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (scan_step) begin
			if (scan_id_eq && !hit_q) begin
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rd_rank;
			end
			if (scan_lru_eq && !lru_q) begin
				lru_idx_q <= idx_s1;
				lru_id_q  <= rd_id;
			end
			if (scan_free && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == lopt_pkg::ST_DECIDE) begin
			res_outcome_q <= dec_outcome;
			res_evicted_q <= dec_evicted;
			mode_q        <= dec_mode;
			ins_idx_q     <= f_idx;
		end
		if ((state_q == lopt_pkg::ST_FINISH) && rsp_free) begin
			out_outcome_q <= res_outcome_q;
			out_evicted_q <= res_evicted_q;
			out_count_q   <= count_q;
		end
	end

	assign req.ready      = (state_q == lopt_pkg::ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.outcome    = out_outcome_q;
	assign rsp.evicted_id = out_evicted_q;
	assign rsp.open_count = out_count_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("held count disagrees with valid bits");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("held count exceeds table size");

	a_evicted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.outcome != lopt_pkg::OUT_EVICTED)) |-> (rsp.evicted_id == '0))
		else $error("evicted id set without eviction");

	a_insert_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == lopt_pkg::ST_UPDATE) && (mode_q == lopt_pkg::UPD_INS)) |->
		valid_q[ins_idx_q])
		else $error("insert slot not marked valid");

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for lru_open_partition_table_unit (LRU table of open partition ids).
// Depends on lopt_pkg, lopt_if and the unit itself; stands alone otherwise.
// Walks a directed script, then randomized phases under several capacity/eviction settings.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES  = 16;
	localparam int ID_BITS  = 32;
	localparam int CNT_W    = 5;
	// Wait allowed for one access or release, used in the final drain
	localparam int LATENCY  = 2 * ENTRIES + 4;
	localparam int PHASE_WORDS = 155;
	localparam int HOLD_AT     = 300;   // response index where the receiver backs off
	localparam int HOLD_CYCLES = 500;
	localparam int CYCLE_LIMIT = 600000;

	// The unused kind: its high bit makes it a clear all
	localparam logic [lopt_pkg::KIND_W-1:0] KIND_CLEAR_ALT = 2'd3;

	typedef struct packed {
		lopt_pkg::outcome_t   outcome;
		logic [ID_BITS-1:0]   evicted;
		logic [CNT_W-1:0]     count;
	} rsp_word_t;

	typedef struct {
		bit                              is_cfg;
		logic [lopt_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [lopt_pkg::CFG_DATA_W-1:0] reg_val;
		logic [lopt_pkg::KIND_W-1:0]     kind;
		logic [ID_BITS-1:0]              id;
		bit                              known;
		rsp_word_t                       hand;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lopt_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lopt_pkg::CFG_DATA_W-1:0] cfg_data;

	lopt_req_if #(.ID_BITS(ID_BITS)) req_ch ();
	lopt_rsp_if #(.ID_BITS(ID_BITS), .CNT_W(CNT_W)) rsp_ch ();

	lru_open_partition_table_unit #(
		.ENTRIES (ENTRIES),
		.ID_BITS (ID_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Table predictor: own copy of the slots, their recency and the registers
	// ------------------------------------------------------------------
	logic [ID_BITS-1:0] slot_id_m   [ENTRIES];
	bit                 slot_live_m [ENTRIES];
	int unsigned        slot_rank_m [ENTRIES];
	int unsigned        held_m;
	logic [lopt_pkg::CFG_DATA_W-1:0] cap_m;
	bit                 evict_m;

	rsp_word_t awaited_rsp_q [$];   // responses the unit still owes, oldest first
	int errors;
	int sent_n;
	int taken_n;

	// Empty every slot (clear all, and the state after reset)
	function automatic void wipe_slots();
		for (int i = 0; i < ENTRIES; i++) begin
			slot_id_m[i]   = '0;
			slot_live_m[i] = 1'b0;
			slot_rank_m[i] = 0;
		end
		held_m = 0;
	endfunction

	// Drop a live slot and close the rank gap it leaves behind
	function automatic void retire_slot(input int s);
		int unsigned r;
		r = slot_rank_m[s];
		slot_live_m[s] = 1'b0;
		slot_rank_m[s] = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live_m[i] && slot_rank_m[i] > r)
				slot_rank_m[i]--;
		if (held_m > 0)
			held_m--;
	endfunction

	// Apply one request word to the predicted table and return its response
	function automatic rsp_word_t lru_step(input logic [lopt_pkg::KIND_W-1:0] k,
			input logic [ID_BITS-1:0] id);
		rsp_word_t r;
		int hit;
		int victim;
		int vacant;
		int unsigned lim;
		bit full;
		r.outcome = lopt_pkg::OUT_HIT;
		r.evicted = '0;
		hit = -1;
		victim = -1;
		vacant = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && slot_live_m[i] && slot_id_m[i] == id)
				hit = i;
		// Capacity 0 acts as 1, anything above the slot count as the slot count
		lim = (cap_m == 0) ? 1 : ((cap_m > ENTRIES) ? ENTRIES : cap_m);
		if (k[1]) begin
			wipe_slots();
			r.outcome = lopt_pkg::OUT_CLEARED;
		end else if (k == lopt_pkg::KIND_RELEASE) begin
			if (hit >= 0) begin
				retire_slot(hit);
				r.outcome = lopt_pkg::OUT_RELEASED;
			end else begin
				r.outcome = lopt_pkg::OUT_NOT_FOUND;
			end
		end else if (hit >= 0) begin
			// Hit: everything more recent than it ages by one, it becomes rank 0
			for (int i = 0; i < ENTRIES; i++)
				if (slot_live_m[i] && slot_rank_m[i] < slot_rank_m[hit])
					slot_rank_m[i]++;
			slot_rank_m[hit] = 0;
			r.outcome = lopt_pkg::OUT_HIT;
		end else begin
			full = (held_m >= lim);
			if (full && !evict_m) begin
				r.outcome = lopt_pkg::OUT_REFUSED;
			end else begin
				r.outcome = lopt_pkg::OUT_OPENED;
				if (full && held_m > 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (victim < 0 && slot_live_m[i] && slot_rank_m[i] == held_m - 1)
							victim = i;
					if (victim >= 0) begin
						r.evicted = slot_id_m[victim];
						retire_slot(victim);
						r.outcome = lopt_pkg::OUT_EVICTED;
					end
				end
				// New id lands in the lowest-numbered free slot
				for (int i = 0; i < ENTRIES; i++)
					if (vacant < 0 && !slot_live_m[i])
						vacant = i;
				if (vacant < 0) begin
					r.outcome = lopt_pkg::OUT_REFUSED;
					r.evicted = '0;
				end else begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot_live_m[i])
							slot_rank_m[i]++;
					slot_id_m[vacant]   = id;
					slot_live_m[vacant] = 1'b1;
					slot_rank_m[vacant] = 0;
					held_m++;
				end
			end
		end
		r.count = held_m[CNT_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed script rows
	// ------------------------------------------------------------------
	function automatic script_row_t row_item(input logic [lopt_pkg::KIND_W-1:0] k,
			input logic [ID_BITS-1:0] id);
		script_row_t row;
		row = '{default: '0};
		row.kind = k;
		row.id   = id;
		return row;
	endfunction

	function automatic script_row_t row_known(input logic [lopt_pkg::KIND_W-1:0] k,
			input logic [ID_BITS-1:0] id, input lopt_pkg::outcome_t oc,
			input logic [ID_BITS-1:0] ev, input logic [CNT_W-1:0] cnt);
		script_row_t row;
		row = row_item(k, id);
		row.known        = 1'b1;
		row.hand.outcome = oc;
		row.hand.evicted = ev;
		row.hand.count   = cnt;
		return row;
	endfunction

	function automatic script_row_t row_reg(input logic [lopt_pkg::CFG_IDX_W-1:0] idx,
			input logic [lopt_pkg::CFG_DATA_W-1:0] val);
		script_row_t row;
		row = '{default: '0};
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	// Offer one word; keep valid high when the next word follows without a gap
	task automatic offer_word(input logic [lopt_pkg::KIND_W-1:0] k,
			input logic [ID_BITS-1:0] id, input bit known, input rsp_word_t hand);
		int gap;
		rsp_word_t want;
		// every third stretch of 80 words goes back to back
		gap = ((sent_n / 80) % 3 == 0) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= k;
		req_ch.partition_id <= id;
		do @(posedge clk); while (!req_ch.ready);
		want = lru_step(k, id);
		if (known)
			want = hand;
		awaited_rsp_q.push_back(want);
		sent_n++;
	endtask

	// Drain the unit, then write one register; the predictor follows the write
	task automatic write_reg(input logic [lopt_pkg::CFG_IDX_W-1:0] idx,
			input logic [lopt_pkg::CFG_DATA_W-1:0] val);
		req_ch.valid <= 1'b0;
		while (awaited_rsp_q.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lopt_pkg::REG_CAPACITY)
			cap_m = val;
		else
			evict_m = val[0];
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Response side: random back-pressure, one long hold-off
	// ------------------------------------------------------------------
	initial begin : rsp_stall
		int hold;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken_n == HOLD_AT)
				hold = HOLD_CYCLES;
			else if ((taken_n / 70) % 3 == 1)
				hold = 0;
			else
				hold = $urandom_range(0, 12);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken_n++;
		end
	end

	// Compare every accepted response word against the oldest expectation
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsp_q.size() == 0) begin
				$error("response with nothing awaited: outcome %0d evicted_id %h open_count %0d",
					rsp_ch.outcome, rsp_ch.evicted_id, rsp_ch.open_count);
				errors++;
			end else begin
				want = awaited_rsp_q.pop_front();
				if (rsp_ch.outcome !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, rsp_ch.outcome);
					errors++;
				end
				if (rsp_ch.evicted_id !== want.evicted) begin
					$error("evicted_id: expected %h, got %h", want.evicted, rsp_ch.evicted_id);
					errors++;
				end
				if (rsp_ch.open_count !== want.count) begin
					$error("open_count: expected %0d, got %0d", want.count, rsp_ch.open_count);
					errors++;
				end
			end
		end
	end

	// Watchdog
	int cycles;
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("lru_open_partition_table_unit regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		script_row_t script [$];
		logic [ID_BITS-1:0] id_pool [32];
		logic [lopt_pkg::CFG_DATA_W-1:0] phase_cap [10];
		bit phase_evict [10];
		int pool_n;
		int clear_pct;
		int pick;
		logic [lopt_pkg::KIND_W-1:0] k;
		logic [ID_BITS-1:0] id;
		rsp_word_t none;

		none = '0;
		errors  = 0;
		sent_n  = 0;
		taken_n = 0;
		cycles  = 0;
		req_ch.valid        = 1'b0;
		req_ch.kind         = lopt_pkg::KIND_ACCESS;
		req_ch.partition_id = '0;
		cfg_we    = 1'b0;
		cfg_index = lopt_pkg::REG_CAPACITY;
		cfg_data  = '0;
		wipe_slots();
		cap_m   = lopt_pkg::CAPACITY_RESET;
		evict_m = 1'b1;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first: capacity 16, eviction on, empty table
		script.push_back(row_known(lopt_pkg::KIND_RELEASE, 32'h0000_0005,
			lopt_pkg::OUT_NOT_FOUND, '0, 5'd0));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h0000_0000,
			lopt_pkg::OUT_OPENED, '0, 5'd1));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'hFFFF_FFFF,
			lopt_pkg::OUT_OPENED, '0, 5'd2));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h0000_0000,
			lopt_pkg::OUT_HIT, '0, 5'd2));
		// Shrink to two: the all-ones id is least recent and goes
		script.push_back(row_reg(lopt_pkg::REG_CAPACITY, 5'd2));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h1234_5678,
			lopt_pkg::OUT_EVICTED, 32'hFFFF_FFFF, 5'd2));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h1234_5678,
			lopt_pkg::OUT_HIT, '0, 5'd2));
		// Eviction off: a miss on a full table is refused, a hit still hits
		script.push_back(row_reg(lopt_pkg::REG_EVICT_ENABLE, 5'd0));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'hA5A5_A5A5,
			lopt_pkg::OUT_REFUSED, '0, 5'd2));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h0000_0000,
			lopt_pkg::OUT_HIT, '0, 5'd2));
		script.push_back(row_known(lopt_pkg::KIND_RELEASE, 32'h1234_5678,
			lopt_pkg::OUT_RELEASED, '0, 5'd1));
		script.push_back(row_known(lopt_pkg::KIND_RELEASE, 32'h1234_5678,
			lopt_pkg::OUT_NOT_FOUND, '0, 5'd1));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h5A5A_5A5A,
			lopt_pkg::OUT_OPENED, '0, 5'd2));
		// Capacity 0 acts as 1, now below the two ids held
		script.push_back(row_reg(lopt_pkg::REG_CAPACITY, 5'd0));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h0000_0001,
			lopt_pkg::OUT_REFUSED, '0, 5'd2));
		// Eviction back on: one out, one in, count stays above capacity; id 0 is evicted
		script.push_back(row_reg(lopt_pkg::REG_EVICT_ENABLE, 5'd1));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h0000_0001,
			lopt_pkg::OUT_EVICTED, 32'h0, 5'd2));
		script.push_back(row_item(lopt_pkg::KIND_ACCESS, 32'h0000_0002));
		// Kind 3 decodes as clear all
		script.push_back(row_known(KIND_CLEAR_ALT, 32'hDEAD_BEEF,
			lopt_pkg::OUT_CLEARED, '0, 5'd0));
		// Capacity far above the slot count acts as the slot count
		script.push_back(row_reg(lopt_pkg::REG_CAPACITY, 5'd31));
		script.push_back(row_known(lopt_pkg::KIND_ACCESS, 32'h8000_0000,
			lopt_pkg::OUT_OPENED, '0, 5'd1));
		script.push_back(row_item(lopt_pkg::KIND_ACCESS, 32'h7FFF_FFFF));
		script.push_back(row_known(lopt_pkg::KIND_CLEAR, 32'h8000_0000,
			lopt_pkg::OUT_CLEARED, '0, 5'd0));

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				offer_word(script[i].kind, script[i].id, script[i].known, script[i].hand);
		end

		// Random phases: the table is not cleared between them, so lowering the
		// capacity finds it holding more ids than allowed
		phase_cap   = '{5'd16, 5'd4, 5'd1, 5'd3, 5'd16, 5'd0, 5'd9, 5'd31, 5'd2, 5'd17};
		phase_evict = '{1'b1,  1'b1, 1'b1, 1'b0, 1'b0,  1'b1, 1'b1, 1'b0,  1'b1, 1'b1};
		for (int p = 0; p < 10; p++) begin
			write_reg(lopt_pkg::REG_CAPACITY, phase_cap[p]);
			write_reg(lopt_pkg::REG_EVICT_ENABLE, {4'd0, phase_evict[p]});
			// A small working set per phase keeps hits, fills and evictions frequent
			pool_n    = $urandom_range(2, 22);
			clear_pct = $urandom_range(0, 4);
			for (int j = 0; j < pool_n; j++) begin
				pick = $urandom_range(0, 19);
				id_pool[j] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < clear_pct)
					k = lopt_pkg::KIND_CLEAR;
				else if (pick < clear_pct + 1)
					k = KIND_CLEAR_ALT;
				else if (pick < 76)
					k = lopt_pkg::KIND_ACCESS;
				else
					k = lopt_pkg::KIND_RELEASE;
				pick = $urandom_range(0, 99);
				if (pick < 85)
					id = id_pool[$urandom_range(0, pool_n - 1)];
				else if (pick < 88)
					id = 32'h0;
				else if (pick < 91)
					id = 32'hFFFF_FFFF;
				else
					id = $urandom;
				offer_word(k, id, 1'b0, none);
			end
		end
		req_ch.valid <= 1'b0;

		// Let every owed response come back, then watch for strays
		while (awaited_rsp_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 16) @(posedge clk);

		if (errors == 0) begin
			$display("lru_open_partition_table_unit regression: pass");
		end else begin
			$display("lru_open_partition_table_unit regression: fail");
		end
		$finish;
	end

endmodule
